>>> sv/sbc_pkg.sv
// Shared types, constants and helpers of the segment box clipper.
package sbc_pkg;

  localparam int QDEPTH    = 8;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int ODEPTH    = 32;
  localparam int OAW       = $clog2(ODEPTH);
  localparam int DIV_STEPS = 16;
  localparam int T_ONE     = 65536;
  localparam int T_CLAMP   = T_ONE + 1;

  typedef enum logic [2:0] {
    REG_U_AXIS = 3'd0,
    REG_V_AXIS = 3'd1,
    REG_U_MIN  = 3'd2,
    REG_U_MAX  = 3'd3,
    REG_V_MIN  = 3'd4,
    REG_V_MAX  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [47:0]        u_axis;
    logic [47:0]        v_axis;
    logic signed [31:0] u_min;
    logic signed [31:0] u_max;
    logic signed [31:0] v_min;
    logic signed [31:0] v_max;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  // Edge order: u >= u_min, u <= u_max, v >= v_min, v <= v_max.
  typedef struct packed {
    vec_t              s;
    vec_t              e;
    logic [3:0][32:0]  ep;
    logic [3:0][32:0]  eq;
  } mid_t;

  typedef struct packed {
    logic        visible;
    vec_t        s;
    vec_t        e;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
    logic signed [31:0] r;
    if (x > 52'sd2147483647)       r = 32'sh7fffffff;
    else if (x < -52'sd2147483648) r = 32'sh80000000;
    else                           r = x[31:0];
    return r;
  endfunction

endpackage

>>> sv/sbc_front.sv
// Front part: projects both endpoints onto the plane axes and sets up the edge terms.
module sbc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  sbc_pkg::cfg_t cfg,
  input  logic          in_fire,
  input  sbc_pkg::vec_t in_s,
  input  sbc_pkg::vec_t in_e,
  output logic          push,
  output sbc_pkg::mid_t push_data
);

  logic signed [31:0] crd [2][3];
  logic signed [15:0] cmp [2][3];

  logic               v1_r, v2_r, v3_r;
  logic signed [47:0] prod_r [2][2][3];
  logic signed [31:0] proj_r [2][2];
  sbc_pkg::vec_t      s1_r, e1_r, s2_r, e2_r;
  sbc_pkg::mid_t      mid_r;

  always_comb begin
    crd[0][0] = in_s.x; crd[0][1] = in_s.y; crd[0][2] = in_s.z;
    crd[1][0] = in_e.x; crd[1][1] = in_e.y; crd[1][2] = in_e.z;
    for (int k = 0; k < 3; k++) begin
      cmp[0][k] = cfg.u_axis[16*k +: 16];
      cmp[1][k] = cfg.v_axis[16*k +: 16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [49:0] acc;
    logic signed [35:0] sh;
    logic signed [32:0] a0, b0, du, dv;
    s1_r <= in_s;
    e1_r <= in_e;
    for (int pt = 0; pt < 2; pt++)
      for (int ax = 0; ax < 2; ax++)
        for (int k = 0; k < 3; k++)
          prod_r[pt][ax][k] <= crd[pt][k] * cmp[ax][k];
    s2_r <= s1_r;
    e2_r <= e1_r;
    for (int pt = 0; pt < 2; pt++)
      for (int ax = 0; ax < 2; ax++) begin
        acc = 50'(prod_r[pt][ax][0]) + 50'(prod_r[pt][ax][1]) + 50'(prod_r[pt][ax][2]);
        sh  = 36'(acc >>> 14);
        proj_r[pt][ax] <= sbc_pkg::sat32(52'(sh));
      end
    a0 = 33'(proj_r[0][0]);
    b0 = 33'(proj_r[0][1]);
    du = 33'(proj_r[1][0]) - a0;
    dv = 33'(proj_r[1][1]) - b0;
    mid_r.s     <= s2_r;
    mid_r.e     <= e2_r;
    mid_r.ep[0] <= -du;
    mid_r.eq[0] <= a0 - 33'(cfg.u_min);
    mid_r.ep[1] <= du;
    mid_r.eq[1] <= 33'(cfg.u_max) - a0;
    mid_r.ep[2] <= -dv;
    mid_r.eq[2] <= b0 - 33'(cfg.v_min);
    mid_r.ep[3] <= dv;
    mid_r.eq[3] <= 33'(cfg.v_max) - b0;
  end

  assign push      = v3_r;
  assign push_data = mid_r;

endmodule

>>> sv/sbc_queue.sv
// Short queue between the front and back parts.
module sbc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sbc_pkg::mid_t push_data,
  input  logic          pop,
  output logic          head_valid,
  output sbc_pkg::mid_t head_data
);

  sbc_pkg::mid_t           mem [sbc_pkg::QDEPTH];
  logic [sbc_pkg::QAW:0]   wr_r, rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r[sbc_pkg::QAW-1:0]] <= push_data;
  end

  assign head_valid = (wr_r != rd_r);
  assign head_data  = mem[rd_r[sbc_pkg::QAW-1:0]];

endmodule

>>> sv/sbc_back.sv
// Back part: edge divisions, Liang-Barsky combine, interpolation and result buffer.
module sbc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  sbc_pkg::mid_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output sbc_pkg::res_t out_data
);

  typedef struct packed {
    logic [33:0] rem;
    logic [32:0] den;
    logic [16:0] quo;
    logic        neg;
    logic        par;
    logic        parok;
    logic        pneg;
    logic        big;
  } edge_div_t;

  typedef struct packed {
    sbc_pkg::vec_t        s;
    sbc_pkg::vec_t        e;
    edge_div_t [3:0]      ed;
  } div_st_t;

  localparam int NST = sbc_pkg::DIV_STEPS + 1;

  div_st_t            div_r   [NST];
  logic [NST-1:0]     div_v_r;

  logic               lb_v_r, lb_ok_r;
  logic [16:0]        tmin_r, tmax_r;
  sbc_pkg::vec_t      lb_s_r, lb_e_r;

  logic               mu_v_r, mu_ok_r;
  logic signed [50:0] d_r [2][3];
  sbc_pkg::vec_t      mu_s_r;

  sbc_pkg::res_t      omem [sbc_pkg::ODEPTH];
  logic [sbc_pkg::OAW:0] owr_r, ord_r, cnt_r;
  logic               fin_push, out_pop;
  sbc_pkg::res_t      fin_data;

  // Reserve a buffer slot for every item that enters the back part.
  assign q_pop   = q_valid && (cnt_r < (sbc_pkg::OAW+1)'(sbc_pkg::ODEPTH));
  assign out_pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_v_r <= '0;
      lb_v_r  <= 1'b0;
      mu_v_r  <= 1'b0;
      owr_r   <= '0;
      ord_r   <= '0;
      cnt_r   <= '0;
    end else begin
      div_v_r <= {div_v_r[NST-2:0], q_pop};
      lb_v_r  <= div_v_r[NST-1];
      mu_v_r  <= lb_v_r;
      if (fin_push) owr_r <= owr_r + 1'b1;
      if (out_pop)  ord_r <= ord_r + 1'b1;
      cnt_r <= cnt_r + (sbc_pkg::OAW+1)'(q_pop) - (sbc_pkg::OAW+1)'(out_pop);
    end
  end

  // Setup and one quotient bit per stage.
  always_ff @(posedge clk) begin
    logic signed [32:0] p, q, num;
    logic [33:0] rem2;
    div_st_t nx;
    div_r[0].s <= q_data.s;
    div_r[0].e <= q_data.e;
    for (int k = 0; k < 4; k++) begin
      p   = q_data.ep[k];
      q   = q_data.eq[k];
      num = p[32] ? -q : q;
      div_r[0].ed[k].pneg  <= p[32];
      div_r[0].ed[k].par   <= (p == '0);
      div_r[0].ed[k].parok <= !q[32];
      div_r[0].ed[k].neg   <= num[32];
      div_r[0].ed[k].den   <= p[32] ? -p : p;
      div_r[0].ed[k].big   <= {1'b0, num} >= {(p[32] ? -p : p), 1'b0};
      if (num >= 33'(p[32] ? -p : p) && !num[32]) begin
        div_r[0].ed[k].quo <= 17'd1;
        div_r[0].ed[k].rem <= 34'(num) - 34'(p[32] ? -p : p);
      end else begin
        div_r[0].ed[k].quo <= 17'd0;
        div_r[0].ed[k].rem <= 34'(num);
      end
    end
    for (int st = 1; st < NST; st++) begin
      nx = div_r[st-1];
      for (int k = 0; k < 4; k++) begin
        rem2 = {nx.ed[k].rem[32:0], 1'b0};
        if (rem2 >= 34'(nx.ed[k].den)) begin
          nx.ed[k].rem = rem2 - 34'(nx.ed[k].den);
          nx.ed[k].quo = {nx.ed[k].quo[15:0], 1'b1};
        end else begin
          nx.ed[k].rem = rem2;
          nx.ed[k].quo = {nx.ed[k].quo[15:0], 1'b0};
        end
      end
      div_r[st] <= nx;
    end
  end

  // Combine the u_min, u_max, v_min and v_max edges in order.
  always_ff @(posedge clk) begin
    logic signed [17:0] t, tmin, tmax;
    logic ok;
    edge_div_t ed;
    tmin = 18'sd0;
    tmax = 18'(sbc_pkg::T_ONE);
    ok   = 1'b1;
    for (int k = 0; k < 4; k++) begin
      ed = div_r[NST-1].ed[k];
      if (ed.neg)                                t = -18'sd1;
      else if (ed.big || ed.quo > 17'(sbc_pkg::T_CLAMP)) t = 18'(sbc_pkg::T_CLAMP);
      else                                       t = 18'(ed.quo);
      if (ok) begin
        if (ed.par) begin
          ok = ed.parok;
        end else if (ed.pneg) begin
          if (t > tmax)      ok = 1'b0;
          else if (t > tmin) tmin = t;
        end else begin
          if (t < tmin)      ok = 1'b0;
          else if (t < tmax) tmax = t;
        end
      end
    end
    lb_ok_r <= ok;
    tmin_r  <= tmin[16:0];
    tmax_r  <= tmax[16:0];
    lb_s_r  <= div_r[NST-1].s;
    lb_e_r  <= div_r[NST-1].e;
  end

  always_ff @(posedge clk) begin
    logic signed [32:0] df [3];
    df[0] = 33'(lb_e_r.x) - 33'(lb_s_r.x);
    df[1] = 33'(lb_e_r.y) - 33'(lb_s_r.y);
    df[2] = 33'(lb_e_r.z) - 33'(lb_s_r.z);
    for (int k = 0; k < 3; k++) begin
      d_r[0][k] <= df[k] * $signed({1'b0, tmin_r});
      d_r[1][k] <= df[k] * $signed({1'b0, tmax_r});
    end
    mu_ok_r <= lb_ok_r;
    mu_s_r  <= lb_s_r;
  end

  always_comb begin
    logic signed [31:0] a [3];
    logic signed [31:0] r [2][3];
    logic signed [50:0] rnd;
    a[0] = mu_s_r.x; a[1] = mu_s_r.y; a[2] = mu_s_r.z;
    for (int j = 0; j < 2; j++)
      for (int k = 0; k < 3; k++) begin
        rnd     = (d_r[j][k] + 51'sd32768) >>> 16;
        r[j][k] = mu_ok_r ? sbc_pkg::sat32(52'(rnd) + 52'(a[k])) : 32'sd0;
      end
    fin_data.visible = mu_ok_r;
    fin_data.s = {r[0][0], r[0][1], r[0][2]};
    fin_data.e = {r[1][0], r[1][1], r[1][2]};
    fin_push = mu_v_r;
  end

  always_ff @(posedge clk) begin
    if (fin_push) omem[owr_r[sbc_pkg::OAW-1:0]] <= fin_data;
  end

  assign out_valid = (owr_r != ord_r);
  assign out_data  = omem[ord_r[sbc_pkg::OAW-1:0]];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (sbc_pkg::OAW+1)'(sbc_pkg::ODEPTH))
    else $error("back reservation count overrun");
  a_buf_room: assert property (@(posedge clk) disable iff (!rst_n)
    fin_push |-> ((owr_r - ord_r) < (sbc_pkg::OAW+1)'(sbc_pkg::ODEPTH)))
    else $error("result buffer written while full");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

>>> sv/segment_box_clipper_unit.sv
// Top level of the segment box clipper: config registers, front, queue, back.
//
//  channel  | dir | handshake              | payload
//  in_      | in  | in_tvalid / in_tready  | in_tdata  192b: start_x,y,z, end_x,y,z
//  out_     | out | out_tvalid / out_tready| out_tdata 192b clipped ends, out_tuser visible
//  cfg_     | in  | cfg_we                 | cfg_addr 3b, cfg_wdata 48b
//
// One segment per cycle sustained while out_tready stays high; an in beat passes through
// 3 projection stages, queue, setup, 16 divider stages, combine, multiply and result buffer to the out beat.
// The 16-stage restoring divider sets the latency; throughput stays one per cycle while the output is not stalled.
// Reset is synchronous; only the valid, pointer, count and config registers have reset values.
// The result buffer holds 32 items and the queue 8, so either side may stall freely.
module segment_box_clipper_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,   // start_x, start_y, start_z, end_x, end_y, end_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // clip_start_x,y,z, clip_end_x,y,z
  output logic [0:0]   out_tuser,  // visible
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [47:0]  cfg_wdata
);

  sbc_pkg::cfg_t         cfg_r;
  logic [sbc_pkg::QAW:0] fcnt_r;
  logic                  in_fire, push, q_valid, q_pop;
  sbc_pkg::mid_t         push_data, q_data;
  sbc_pkg::vec_t         in_s, in_e;
  sbc_pkg::res_t         res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.u_axis <= '0;
      cfg_r.v_axis <= '0;
      cfg_r.u_min  <= 32'sh80000000;
      cfg_r.u_max  <= 32'sh7fffffff;
      cfg_r.v_min  <= 32'sh80000000;
      cfg_r.v_max  <= 32'sh7fffffff;
    end else if (cfg_we) begin
      case (cfg_addr)
        sbc_pkg::REG_U_AXIS: cfg_r.u_axis <= cfg_wdata;
        sbc_pkg::REG_V_AXIS: cfg_r.v_axis <= cfg_wdata;
        sbc_pkg::REG_U_MIN:  cfg_r.u_min  <= cfg_wdata[31:0];
        sbc_pkg::REG_U_MAX:  cfg_r.u_max  <= cfg_wdata[31:0];
        sbc_pkg::REG_V_MIN:  cfg_r.v_min  <= cfg_wdata[31:0];
        sbc_pkg::REG_V_MAX:  cfg_r.v_max  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Count items in the front stages and the queue; hold off when the queue could fill.
  assign in_tready = fcnt_r < (sbc_pkg::QAW+1)'(sbc_pkg::QDEPTH);
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) fcnt_r <= '0;
    else        fcnt_r <= fcnt_r + (sbc_pkg::QAW+1)'(in_fire) - (sbc_pkg::QAW+1)'(q_pop);
  end

  assign in_s = {in_tdata[31:0],   in_tdata[63:32],   in_tdata[95:64]};
  assign in_e = {in_tdata[127:96], in_tdata[159:128], in_tdata[191:160]};

  sbc_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .in_fire(in_fire),
    .in_s(in_s), .in_e(in_e), .push(push), .push_data(push_data)
  );

  sbc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .pop(q_pop), .head_valid(q_valid), .head_data(q_data)
  );

  sbc_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(res)
  );

  assign out_tdata = {res.e.z, res.e.y, res.e.x, res.s.z, res.s.y, res.s.x};
  assign out_tuser = res.visible;

  a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= (sbc_pkg::QAW+1)'(sbc_pkg::QDEPTH))
    else $error("front reservation count overrun");
  a_push_counted: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fcnt_r != '0))
    else $error("queue push with no reserved slot");
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (fcnt_r == (sbc_pkg::QAW+1)'(sbc_pkg::QDEPTH)))
    else $error("input stalled with free slots");

endmodule
